// ----- hdl/bmhq_pkg.sv -----
// Shared types, codes and the microcode program of the binary max-heap queue.
package bmhq_pkg;

    localparam int HEAP_DEPTH_DEF = 16;
    localparam int VALUE_W        = 32;
    localparam int COUNT_W        = 5;
    localparam int STATUS_W       = 2;
    localparam int UPC_W          = 5;
    localparam int ACT_W          = 4;
    localparam int COND_W         = 4;

    typedef logic [UPC_W-1:0]    upc_t;
    typedef logic [ACT_W-1:0]    act_t;
    typedef logic [COND_W-1:0]   cond_t;
    typedef logic [STATUS_W-1:0] status_t;

    // Result status codes.
    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_FULL  = 2'd2;

    // Datapath actions, one per control word.
    localparam act_t A_NOP       = 4'd0;
    localparam act_t A_LOAD      = 4'd1;
    localparam act_t A_PUSH_INIT = 4'd2;
    localparam act_t A_RD_PARENT = 4'd3;
    localparam act_t A_UP_MOVE   = 4'd4;
    localparam act_t A_PLACE     = 4'd5;
    localparam act_t A_POP_INIT  = 4'd6;
    localparam act_t A_LOAD_LAST = 4'd7;
    localparam act_t A_RD_LEFT   = 4'd8;
    localparam act_t A_RD_RIGHT  = 4'd9;
    localparam act_t A_PICK      = 4'd10;
    localparam act_t A_DN_MOVE   = 4'd11;
    localparam act_t A_SET_FULL  = 4'd12;
    localparam act_t A_SET_EMPTY = 4'd13;
    localparam act_t A_DONE      = 4'd14;

    // Jump conditions; a taken jump loads the target, otherwise the step counter advances.
    localparam cond_t C_NEVER    = 4'd0;
    localparam cond_t C_ALWAYS   = 4'd1;
    localparam cond_t C_NOGO     = 4'd2;
    localparam cond_t C_POP      = 4'd3;
    localparam cond_t C_FULL     = 4'd4;
    localparam cond_t C_POS0     = 4'd5;
    localparam cond_t C_PLESS    = 4'd6;
    localparam cond_t C_EMPTY    = 4'd7;
    localparam cond_t C_NOKID    = 4'd8;
    localparam cond_t C_NORIGHT  = 4'd9;
    localparam cond_t C_KGE      = 4'd10;
    localparam cond_t C_OUTBUSY  = 4'd11;

    // Program addresses.
    localparam upc_t U_IDLE    = 5'd0;
    localparam upc_t U_DISP    = 5'd1;
    localparam upc_t U_PCHK    = 5'd2;
    localparam upc_t U_PINIT   = 5'd3;
    localparam upc_t U_UPRD    = 5'd4;
    localparam upc_t U_UPCMP   = 5'd5;
    localparam upc_t U_PLACE   = 5'd6;
    localparam upc_t U_POPCHK  = 5'd7;
    localparam upc_t U_POPINIT = 5'd8;
    localparam upc_t U_POPLD   = 5'd9;
    localparam upc_t U_DNRD    = 5'd10;
    localparam upc_t U_DNRDR   = 5'd11;
    localparam upc_t U_DNPICK  = 5'd12;
    localparam upc_t U_DNCMP   = 5'd13;
    localparam upc_t U_PLACE2  = 5'd14;
    localparam upc_t U_FULL    = 5'd15;
    localparam upc_t U_DWAIT   = 5'd16;
    localparam upc_t U_DONE    = 5'd17;
    localparam upc_t U_EMPTY   = 5'd18;

    typedef struct packed {
        act_t  act;
        cond_t cond;
        upc_t  target;
    } uword_t;

    typedef struct packed {
        logic go;
        logic mode;
        logic out_busy;
    } core_ctl_t;

    typedef struct packed {
        logic idle;
        logic done;
    } core_stat_t;

    typedef struct packed {
        status_t                    status;
        logic [COUNT_W-1:0]         count;
        logic signed [VALUE_W-1:0]  top;
        logic signed [VALUE_W-1:0]  popped;
    } result_t;

    // Control store: one word per step.
    function automatic uword_t ucode(input upc_t addr);
        uword_t w;
        case (addr)
            U_IDLE:    w = '{A_LOAD,      C_NOGO,    U_IDLE};
            U_DISP:    w = '{A_NOP,       C_POP,     U_POPCHK};
            U_PCHK:    w = '{A_NOP,       C_FULL,    U_FULL};
            U_PINIT:   w = '{A_PUSH_INIT, C_NEVER,   U_IDLE};
            U_UPRD:    w = '{A_RD_PARENT, C_POS0,    U_PLACE};
            U_UPCMP:   w = '{A_UP_MOVE,   C_PLESS,   U_UPRD};
            U_PLACE:   w = '{A_PLACE,     C_ALWAYS,  U_DWAIT};
            U_POPCHK:  w = '{A_NOP,       C_EMPTY,   U_EMPTY};
            U_POPINIT: w = '{A_POP_INIT,  C_NEVER,   U_IDLE};
            U_POPLD:   w = '{A_LOAD_LAST, C_NEVER,   U_IDLE};
            U_DNRD:    w = '{A_RD_LEFT,   C_NOKID,   U_PLACE};
            U_DNRDR:   w = '{A_RD_RIGHT,  C_NORIGHT, U_DNCMP};
            U_DNPICK:  w = '{A_PICK,      C_NEVER,   U_IDLE};
            U_DNCMP:   w = '{A_DN_MOVE,   C_KGE,     U_DNRD};
            U_PLACE2:  w = '{A_PLACE,     C_ALWAYS,  U_DWAIT};
            U_FULL:    w = '{A_SET_FULL,  C_ALWAYS,  U_DWAIT};
            U_DWAIT:   w = '{A_NOP,       C_OUTBUSY, U_DWAIT};
            U_DONE:    w = '{A_DONE,      C_ALWAYS,  U_IDLE};
            U_EMPTY:   w = '{A_SET_EMPTY, C_ALWAYS,  U_DWAIT};
            default:   w = '{A_NOP,       C_ALWAYS,  U_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ----- hdl/binary_max_heap_queue_unit.sv -----
// Top level of the binary max-heap priority queue with stream ports and output register.
//
//   Channel   Direction  Beat contents
//   s_axis    in         tuser: mode; tdata: value
//   m_axis    out        tdata: popped, top, count, status (zero padded to 72 bits)
//
// Each beat runs through a short microcode program; the block takes one beat at a time.
// Each level a pushed value rises is a read of its parent and a compare; each level the
// moved entry of a pop sinks is a read of the left and then the right child through the
// single read port of the heap memory, a pick of the larger one where both exist and a compare.
// After reset the heap is empty and ready at once; no memory clearing is needed.
// A result waits in the output register while the next beat is accepted; the sequencer
// holds its wait step before the result until that register is free.
module binary_max_heap_queue_unit #(
    parameter int HEAP_DEPTH = bmhq_pkg::HEAP_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    input  logic        s_axis_tuser,   // [0] mode: 0 push, 1 pop
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata    // [31:0] popped, [63:32] top, [68:64] count,
                                        // [70:69] status, [71] zero
);

    bmhq_pkg::core_ctl_t  ctl;
    bmhq_pkg::core_stat_t stat;
    bmhq_pkg::result_t    res;

    logic                 m_valid_reg, m_valid_next;
    bmhq_pkg::result_t    m_res_reg;

    // The sequencer only takes a beat while it sits in its idle step.
    assign s_axis_tready = stat.idle;
    assign ctl.go        = s_axis_tvalid && stat.idle;
    assign ctl.mode      = s_axis_tuser;
    assign ctl.out_busy  = m_valid_reg && !m_axis_tready;

    bmhq_core #(
        .HEAP_DEPTH (HEAP_DEPTH)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .value ($signed(s_axis_tdata)),
        .stat  (stat),
        .res   (res)
    );

    // Output register: loaded on a finished item, cleared when the beat is taken.
    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (stat.done)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stat.done)
        begin
            m_res_reg <= res;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {1'b0, m_res_reg};

endmodule

// ----- hdl/bmhq_core.sv -----
// Microcoded sequencer, heap memory and datapath of the binary max-heap queue.
module bmhq_core #(
    parameter int HEAP_DEPTH = bmhq_pkg::HEAP_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bmhq_pkg::core_ctl_t         ctl,
    input  logic signed [31:0]          value,
    output bmhq_pkg::core_stat_t        stat,
    output bmhq_pkg::result_t           res
);

    localparam int IW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
    localparam int CW = $clog2(HEAP_DEPTH + 1);

    logic signed [31:0] mem [HEAP_DEPTH];

    bmhq_pkg::upc_t      upc_reg, upc_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [IW-1:0]       pos_reg, pos_next;
    logic [IW-1:0]       kidx_reg, kidx_next;
    logic signed [31:0]  val_reg, val_next;
    logic signed [31:0]  kid_reg, kid_next;
    logic signed [31:0]  top_reg, top_next;
    logic signed [31:0]  popped_reg, popped_next;
    bmhq_pkg::status_t   status_reg, status_next;
    logic                mode_reg, mode_next;
    logic signed [31:0]  rdata_reg;

    bmhq_pkg::uword_t    uw;
    logic                take;
    logic [IW+1:0]       left_w, right_w, cnt_x;
    logic [IW-1:0]       parent_w, last_w, rd_addr;
    logic                p_less, k_ge;
    logic                mem_we;
    logic [IW-1:0]       mem_wa;
    logic signed [31:0]  mem_wd;
    logic [31:0]         cnt_wide;

    assign uw       = bmhq_pkg::ucode(upc_reg);
    assign left_w   = {1'b0, pos_reg, 1'b1};
    assign right_w  = left_w + (IW+2)'(1);
    assign cnt_x    = (IW+2)'(cnt_reg);
    assign parent_w = (pos_reg - IW'(1)) >> 1;
    assign last_w   = IW'(cnt_reg - CW'(1));
    assign p_less   = rdata_reg < val_reg;
    assign k_ge     = !(kid_reg < val_reg);

    always_comb
    begin
        case (uw.cond)
            bmhq_pkg::C_NEVER:   take = 1'b0;
            bmhq_pkg::C_ALWAYS:  take = 1'b1;
            bmhq_pkg::C_NOGO:    take = !ctl.go;
            bmhq_pkg::C_POP:     take = mode_reg;
            bmhq_pkg::C_FULL:    take = 32'(cnt_reg) >= 32'(HEAP_DEPTH);
            bmhq_pkg::C_POS0:    take = pos_reg == '0;
            bmhq_pkg::C_PLESS:   take = p_less;
            bmhq_pkg::C_EMPTY:   take = cnt_reg == '0;
            bmhq_pkg::C_NOKID:   take = left_w >= cnt_x;
            bmhq_pkg::C_NORIGHT: take = right_w >= cnt_x;
            bmhq_pkg::C_KGE:     take = k_ge;
            bmhq_pkg::C_OUTBUSY: take = ctl.out_busy;
            default:             take = 1'b0;
        endcase
        upc_next = take ? uw.target : upc_reg + bmhq_pkg::UPC_W'(1);
    end

    // Datapath: the hole being sifted sits at pos_reg and the moving value in val_reg.
    always_comb
    begin
        cnt_next    = cnt_reg;
        pos_next    = pos_reg;
        kidx_next   = kidx_reg;
        val_next    = val_reg;
        kid_next    = kid_reg;
        popped_next = popped_reg;
        status_next = status_reg;
        mode_next   = mode_reg;
        mem_we      = 1'b0;
        mem_wa      = pos_reg;
        mem_wd      = val_reg;
        rd_addr     = pos_reg;
        case (uw.act)
            bmhq_pkg::A_LOAD:
            begin
                if (ctl.go)
                begin
                    val_next  = value;
                    mode_next = ctl.mode;
                end
            end
            bmhq_pkg::A_PUSH_INIT:
            begin
                pos_next    = IW'(cnt_reg);
                cnt_next    = cnt_reg + CW'(1);
                popped_next = '0;
                status_next = bmhq_pkg::ST_OK;
            end
            bmhq_pkg::A_RD_PARENT:
            begin
                rd_addr = parent_w;
            end
            bmhq_pkg::A_UP_MOVE:
            begin
                if (p_less)
                begin
                    mem_we   = 1'b1;
                    mem_wd   = rdata_reg;
                    pos_next = parent_w;
                end
            end
            bmhq_pkg::A_PLACE:
            begin
                mem_we = 1'b1;
            end
            bmhq_pkg::A_POP_INIT:
            begin
                rd_addr     = last_w;
                popped_next = top_reg;
                cnt_next    = cnt_reg - CW'(1);
                pos_next    = '0;
                status_next = bmhq_pkg::ST_OK;
            end
            bmhq_pkg::A_LOAD_LAST:
            begin
                val_next = rdata_reg;
            end
            bmhq_pkg::A_RD_LEFT:
            begin
                rd_addr = left_w[IW-1:0];
            end
            bmhq_pkg::A_RD_RIGHT:
            begin
                rd_addr   = right_w[IW-1:0];
                kid_next  = rdata_reg;
                kidx_next = left_w[IW-1:0];
            end
            bmhq_pkg::A_PICK:
            begin
                // Right child wins only when strictly larger.
                if (kid_reg < rdata_reg)
                begin
                    kid_next  = rdata_reg;
                    kidx_next = right_w[IW-1:0];
                end
            end
            bmhq_pkg::A_DN_MOVE:
            begin
                if (k_ge)
                begin
                    mem_we   = 1'b1;
                    mem_wd   = kid_reg;
                    pos_next = kidx_reg;
                end
            end
            bmhq_pkg::A_SET_FULL:
            begin
                popped_next = '0;
                status_next = bmhq_pkg::ST_FULL;
            end
            bmhq_pkg::A_SET_EMPTY:
            begin
                popped_next = '0;
                status_next = bmhq_pkg::ST_EMPTY;
            end
            default:
            begin
            end
        endcase
        top_next = (mem_we && mem_wa == '0) ? mem_wd : top_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= bmhq_pkg::U_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            upc_reg <= upc_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        kidx_reg   <= kidx_next;
        val_reg    <= val_next;
        kid_reg    <= kid_next;
        top_reg    <= top_next;
        popped_reg <= popped_next;
        status_reg <= status_next;
        mode_reg   <= mode_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rdata_reg <= mem[rd_addr];
    end

    assign cnt_wide   = 32'(cnt_reg);
    assign stat.idle  = upc_reg == bmhq_pkg::U_IDLE;
    assign stat.done  = uw.act == bmhq_pkg::A_DONE;
    assign res.popped = popped_reg;
    assign res.top    = (cnt_reg != '0) ? top_reg : '0;
    assign res.count  = cnt_wide[bmhq_pkg::COUNT_W-1:0];
    assign res.status = status_reg;

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cnt_reg) <= 32'(HEAP_DEPTH))
        else $error("entry count above heap depth");

    a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> 32'(mem_wa) < 32'(HEAP_DEPTH))
        else $error("heap write outside the store");

    a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |-> !ctl.out_busy)
        else $error("result issued while the output beat is held");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |=> stat.idle)
        else $error("sequencer did not return to idle after a result");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (stat.done && status_reg == bmhq_pkg::ST_EMPTY) |-> cnt_reg == '0)
        else $error("empty status with stored entries");
`endif

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench of the binary max-heap priority queue over its stream ports.
module tb_top;

    localparam int DEPTH        = bmhq_pkg::HEAP_DEPTH_DEF;
    localparam int RANDOM_BEATS = 1250;
    localparam int MAX_GAP      = 18;
    localparam int TAIL_CYCLES  = 40;
    localparam int STALL_LIMIT  = 2000;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [31:0] VAL_MAX = 32'h7fff_ffff;
    localparam logic [31:0] VAL_MIN = 32'h8000_0000;

    // One directed beat: the operation and, where it is obvious, the result typed in.
    typedef struct packed {
        logic              mode;
        logic [31:0]       value;
        logic              typed;
        bmhq_pkg::result_t result;
    } stim_row_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;

    // Shadow copy of the heap contents and fill level.
    logic signed [31:0] heap_model [DEPTH];
    int                 heap_fill = 0;

    bmhq_pkg::result_t pending_results [$];

    int errors        = 0;
    int results_seen  = 0;
    int push_beats    = 0;
    int pop_beats     = 0;
    int empty_rejects = 0;
    int full_rejects  = 0;
    int deepest_fill  = 0;
    int stall_cycles  = 0;

    binary_max_heap_queue_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Applies one operation to the shadow heap and returns the result beat it should produce.
    function automatic bmhq_pkg::result_t heap_apply(input logic mode,
                                                     input logic signed [31:0] value);
        bmhq_pkg::result_t  r;
        int                 pos;
        int                 kid;
        int                 up;
        logic signed [31:0] tmp;
        logic               sinking;
        r = '0;
        r.status = bmhq_pkg::ST_OK;
        if (mode == OP_PUSH)
        begin
            if (heap_fill >= DEPTH)
                r.status = bmhq_pkg::ST_FULL;
            else
            begin
                pos = heap_fill;
                heap_model[pos] = value;
                heap_fill++;
                // Rise while the parent is strictly smaller.
                while (pos > 0 && heap_model[(pos - 1) / 2] < heap_model[pos])
                begin
                    up = (pos - 1) / 2;
                    tmp = heap_model[up];
                    heap_model[up] = heap_model[pos];
                    heap_model[pos] = tmp;
                    pos = up;
                end
            end
        end
        else if (heap_fill == 0)
            r.status = bmhq_pkg::ST_EMPTY;
        else
        begin
            r.popped = heap_model[0];
            heap_model[0] = heap_model[heap_fill - 1];
            heap_fill--;
            pos = 0;
            sinking = 1'b1;
            // Sink toward the larger child, the left one on a tie; stop once strictly greater.
            while (sinking && 2 * pos + 1 < heap_fill)
            begin
                kid = 2 * pos + 1;
                if (kid + 1 < heap_fill && heap_model[kid] < heap_model[kid + 1])
                    kid = kid + 1;
                if (heap_model[kid] < heap_model[pos])
                    sinking = 1'b0;
                else
                begin
                    tmp = heap_model[pos];
                    heap_model[pos] = heap_model[kid];
                    heap_model[kid] = tmp;
                    pos = kid;
                end
            end
        end
        r.top = (heap_fill > 0) ? heap_model[0] : '0;
        r.count = bmhq_pkg::COUNT_W'(heap_fill);
        return r;
    endfunction

    function automatic stim_row_t ask(input logic mode, input logic [31:0] value);
        stim_row_t s;
        s = '0;
        s.mode = mode;
        s.value = value;
        return s;
    endfunction

    function automatic stim_row_t ask_checked(input logic mode, input logic [31:0] value,
                                              input logic [31:0] popped, input logic [31:0] top,
                                              input int count,
                                              input bmhq_pkg::status_t status);
        stim_row_t s;
        s = ask(mode, value);
        s.typed = 1'b1;
        s.result.popped = popped;
        s.result.top = top;
        s.result.count = bmhq_pkg::COUNT_W'(count);
        s.result.status = status;
        return s;
    endfunction

    // Presents one beat after the given idle gap, waits for the handshake and records the
    // expected result. Entered and left at a falling edge.
    task automatic send_beat(input stim_row_t s, input int gap);
        bmhq_pkg::result_t predicted;
        logic              accepted;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= s.mode;
        s_axis_tdata  <= s.value;
        accepted = 1'b0;
        while (!accepted)
        begin
            @(posedge clk);
            accepted = s_axis_tready;
        end
        predicted = heap_apply(s.mode, s.value);
        pending_results.push_back(s.typed ? s.result : predicted);
        if (s.mode == OP_PUSH)
            push_beats++;
        else
            pop_beats++;
        if (predicted.status == bmhq_pkg::ST_EMPTY)
            empty_rejects++;
        if (predicted.status == bmhq_pkg::ST_FULL)
            full_rejects++;
        if (heap_fill > deepest_fill)
            deepest_fill = heap_fill;
        @(negedge clk);
    endtask

    // Result side: random back-pressure per beat, with stretches where it stays ready.
    initial
    begin : result_sink
        int gap;
        int taken;
        logic burst;
        taken = 0;
        burst = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (taken % 64 == 0)
                burst = ($urandom_range(0, 3) == 0);
            gap = burst ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            taken++;
            @(negedge clk);
        end
    end

    // Every accepted result beat is compared with the oldest pending expectation.
    always @(posedge clk)
    begin : result_check
        bmhq_pkg::result_t got;
        bmhq_pkg::result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = bmhq_pkg::result_t'(m_axis_tdata[70:0]);
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: result beat with nothing pending: %h", $time, m_axis_tdata);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.popped !== want.popped)
                begin
                    $display("%0t: popped expected %0d, got %0d", $time, want.popped, got.popped);
                    errors++;
                end
                if (got.top !== want.top)
                begin
                    $display("%0t: top expected %0d, got %0d", $time, want.top, got.top);
                    errors++;
                end
                if (got.count !== want.count)
                begin
                    $display("%0t: count expected %0d, got %0d", $time, want.count, got.count);
                    errors++;
                end
                if (got.status !== want.status)
                begin
                    $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
                    errors++;
                end
                if (m_axis_tdata[71] !== 1'b0)
                begin
                    $display("%0t: pad bit expected 0, got %b", $time, m_axis_tdata[71]);
                    errors++;
                end
            end
        end
    end

    // Counts cycles in which neither side completes a beat.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin : watchdog
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("%0t: no beat moved for %0d cycles, %0d results still pending",
                 $time, STALL_LIMIT, pending_results.size());
        $display("FAILURE");
        $finish;
    end

    initial
    begin : stimulus
        stim_row_t   stim_table [$];
        stim_row_t   s;
        int          push_pct;
        logic        sender_burst;
        logic [31:0] value;

        // Empty pop first, then the extremes, then a fill with ties up to and past full,
        // then a partial drain that includes a pop carrying junk in its ignored value field.
        stim_table.push_back(ask_checked(OP_POP, 32'h1234_5678, 0, 0, 0, bmhq_pkg::ST_EMPTY));
        stim_table.push_back(ask_checked(OP_PUSH, VAL_MAX, 0, VAL_MAX, 1, bmhq_pkg::ST_OK));
        stim_table.push_back(ask_checked(OP_POP, 32'h0, VAL_MAX, 0, 0, bmhq_pkg::ST_OK));
        stim_table.push_back(ask_checked(OP_PUSH, VAL_MIN, 0, VAL_MIN, 1, bmhq_pkg::ST_OK));
        stim_table.push_back(ask(OP_PUSH, 32'h0));
        stim_table.push_back(ask(OP_PUSH, 32'hffff_ffff));
        stim_table.push_back(ask(OP_PUSH, 32'd5));
        stim_table.push_back(ask(OP_PUSH, 32'd5));
        stim_table.push_back(ask(OP_PUSH, 32'd5));
        stim_table.push_back(ask(OP_PUSH, VAL_MAX));
        stim_table.push_back(ask(OP_PUSH, VAL_MAX));
        stim_table.push_back(ask(OP_PUSH, 32'd1));
        stim_table.push_back(ask(OP_PUSH, -32'sd100));
        stim_table.push_back(ask(OP_PUSH, 32'h4000_0000));
        stim_table.push_back(ask(OP_PUSH, 32'hc000_0000));
        stim_table.push_back(ask(OP_PUSH, 32'd7));
        stim_table.push_back(ask(OP_PUSH, 32'd3));
        stim_table.push_back(ask(OP_PUSH, 32'd2));
        stim_table.push_back(ask(OP_PUSH, 32'd100));
        stim_table.push_back(ask_checked(OP_PUSH, 32'd9, 0, VAL_MAX, DEPTH, bmhq_pkg::ST_FULL));
        stim_table.push_back(ask(OP_POP, 32'h0));
        stim_table.push_back(ask(OP_POP, 32'h0));
        stim_table.push_back(ask(OP_POP, 32'h0));
        stim_table.push_back(ask(OP_POP, 32'h0));
        stim_table.push_back(ask(OP_POP, 32'hdead_beef));

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (stim_table[i])
            send_beat(stim_table[i], $urandom_range(0, MAX_GAP));

        // Random part: phases lean toward push or pop so the heap both fills up and drains.
        push_pct = 50;
        sender_burst = 1'b0;
        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            if (n % 48 == 0)
            begin
                case ($urandom_range(0, 4))
                    0:       push_pct = 85;
                    1:       push_pct = 65;
                    2:       push_pct = 50;
                    3:       push_pct = 35;
                    default: push_pct = 15;
                endcase
            end
            if (n % 64 == 0)
                sender_burst = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 7))
                0:
                begin
                    case ($urandom_range(0, 3))
                        0:       value = VAL_MAX;
                        1:       value = VAL_MIN;
                        2:       value = 32'h0;
                        default: value = 32'hffff_ffff;
                    endcase
                end
                1, 2:
                begin
                    // Narrow range around zero, so equal keys meet often.
                    value = $urandom_range(0, 8);
                    value = value - 32'd4;
                end
                default: value = $urandom();
            endcase
            s = ask(($urandom_range(1, 100) <= push_pct) ? OP_PUSH : OP_POP, value);
            send_beat(s, sender_burst ? 0 : $urandom_range(0, MAX_GAP));
        end
        s_axis_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d pushes and %0d pops, checked %0d result beats.",
                 push_beats, pop_beats, results_seen);
        $display("Rejected %0d pops on an empty heap and %0d pushes on a full one; peak fill %0d.",
                 empty_rejects, full_rejects, deepest_fill);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/bmhq_pkg.sv
hdl/bmhq_core.sv
hdl/binary_max_heap_queue_unit.sv
sim/tb_top.sv
